/* src/fpts_pkg.sv */
// Shared types, constants and helper functions of the fuzzy phrase table search unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fpts_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_W  = 3;
  localparam int SLOT_W = 10;
  localparam int POS_W  = 3;
  localparam int UNIT_W = 8;
  localparam int KEY_W  = 7;
  localparam int LEN_W  = 4;
  localparam int REF_W  = 32;
  localparam int KCNT_W = 8;
  localparam int CIDX_W = 2;

  // Parameter defaults.
  localparam int DEF_SLOTS     = 1024;
  localparam int DEF_MAX_LEN   = 8;
  localparam int DEF_NUM_UNITS = 128;
  localparam int DEF_MAX_OUT   = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_UNIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HDR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FUZZY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ALL    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PREFER = 3'd5;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FUZZY_EN  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_KEY_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DATA_BASE = 2'd2;

  // Partner value meaning "no partner", also the minor wildcard.
  localparam logic signed [UNIT_W-1:0] NO_PARTNER = -8'sd1;

  typedef struct packed {
    logic signed [UNIT_W-1:0] major;
    logic signed [UNIT_W-1:0] minor;
  } unit_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    unit_t             unit;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  count;
  } load_t;

  typedef struct packed {
    logic              fuzzy_en;
    logic [KCNT_W-1:0] key_count;
    logic [REF_W-1:0]  data_base;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } hit_t;

  typedef struct packed {
    logic              found;
    logic [REF_W-1:0]  phrase_ref;
    logic [SLOT_W-1:0] hit_slot;
    logic [LEN_W-1:0]  hit_length;
    logic              truncated;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_KEYW, S_PINIT, S_PHDR, S_PCHK, S_URD, S_UFZ, S_UCMP,
    S_POFF, S_PLRD, S_PLWR, S_MINIT, S_MRD, S_MPICK, S_MNONE
  } srch_state_t;

  // True when a unit index has an entry in the fuzzy table.
  function automatic logic unit_in_range(input logic signed [UNIT_W-1:0] v,
                                         input int bound);
    return (v >= 8'sd0) && (int'(v) < bound);
  endfunction

endpackage

`default_nettype wire

/* src/fpts_if.sv */
// Request and result channel interfaces of the fuzzy phrase table search unit.
// Depends on fpts_pkg for field widths.
`default_nettype none

interface fpts_in_if;
  import fpts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [SLOT_W-1:0]        slot;
  logic [POS_W-1:0]         position;
  logic signed [UNIT_W-1:0] unit_major;
  logic signed [UNIT_W-1:0] unit_minor;
  logic [KEY_W-1:0]         entry_key;
  logic [LEN_W-1:0]         unit_count;

  modport source (output valid, cmd, slot, position, unit_major, unit_minor,
                  entry_key, unit_count, input ready);
  modport sink (input valid, cmd, slot, position, unit_major, unit_minor,
                entry_key, unit_count, output ready);
endinterface

interface fpts_out_if;
  import fpts_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [REF_W-1:0]  phrase_ref;
  logic [SLOT_W-1:0] hit_slot;
  logic [LEN_W-1:0]  hit_length;
  logic              truncated;
  logic              last;

  modport source (output valid, found, phrase_ref, hit_slot, hit_length, truncated, last,
                  input ready);
  modport sink (input valid, found, phrase_ref, hit_slot, hit_length, truncated, last,
                output ready);
endinterface

`default_nettype wire

/* src/fpts_store.sv */
// Phrase table storage: entry units, entry headers, fuzzy partner table and query units.
// Depends on fpts_pkg. Headers are cleared by a sweep after reset.
`default_nettype none

module fpts_store #(
  parameter int SLOTS     = fpts_pkg::DEF_SLOTS,
  parameter int MAX_LEN   = fpts_pkg::DEF_MAX_LEN,
  parameter int NUM_UNITS = fpts_pkg::DEF_NUM_UNITS,
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW  = (SLOTS * MAX_LEN > 1) ? $clog2(SLOTS * MAX_LEN) : 1,
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int UIW = $clog2(NUM_UNITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ld_valid,
  input  fpts_pkg::load_t                   ld,
  output logic                              busy,
  input  logic [SW-1:0]                     hdr_addr,
  output logic [fpts_pkg::LEN_W-1:0]        hdr_len_q,
  output logic [fpts_pkg::KEY_W-1:0]        hdr_key_q,
  input  logic [AW-1:0]                     eu_addr,
  output fpts_pkg::unit_t                   eu_q,
  input  logic [UIW-1:0]                    fz_addr_a,
  input  logic [UIW-1:0]                    fz_addr_b,
  output logic signed [fpts_pkg::UNIT_W-1:0] fz_q_a,
  output logic signed [fpts_pkg::UNIT_W-1:0] fz_q_b,
  input  logic [PW-1:0]                     qry_pos,
  output fpts_pkg::unit_t                   qry_unit,
  output logic signed [fpts_pkg::UNIT_W-1:0] qry_major0
);
  import fpts_pkg::*;

  logic [LEN_W+KEY_W-1:0]    hdr_mem [SLOTS];
  unit_t                     eu_mem [SLOTS*MAX_LEN];
  logic signed [UNIT_W-1:0]  fz_mem [NUM_UNITS];
  logic [NUM_UNITS-1:0]      fz_vld_r;
  unit_t                     qry_r [MAX_LEN];

  logic                      clearing_r;
  logic [SW-1:0]             clr_r;
  logic [LEN_W+KEY_W-1:0]    hdr_q;
  logic signed [UNIT_W-1:0]  fz_da, fz_db;
  logic                      fz_va, fz_vb;

  logic                      slot_ok, pos_ok, fz_ok;
  logic                      hdr_we, eu_we, fz_we, qry_we;
  logic [SW-1:0]             hdr_waddr;
  logic [LEN_W+KEY_W-1:0]    hdr_wdata;
  logic [LEN_W-1:0]          ld_len;
  logic [AW-1:0]             eu_waddr;

  // Write decode of load requests.
  always_comb begin
    slot_ok  = int'(ld.slot) < SLOTS;
    pos_ok   = int'(ld.position) < MAX_LEN;
    fz_ok    = unit_in_range(ld.unit.major, NUM_UNITS);
    eu_we    = ld_valid && (ld.cmd == CMD_UNIT) && slot_ok && pos_ok;
    fz_we    = ld_valid && (ld.cmd == CMD_FUZZY) && fz_ok;
    qry_we   = ld_valid && (ld.cmd == CMD_QUERY) && pos_ok;
    ld_len   = (int'(ld.count) > MAX_LEN) ? LEN_W'(MAX_LEN) : ld.count;
    eu_waddr = AW'(AW'(SW'(ld.slot)) * AW'(MAX_LEN)) + AW'(ld.position);
    if (clearing_r) begin
      hdr_we    = 1'b1;
      hdr_waddr = clr_r;
      hdr_wdata = '0;
    end else begin
      hdr_we    = ld_valid && (ld.cmd == CMD_HDR) && slot_ok;
      hdr_waddr = SW'(ld.slot);
      hdr_wdata = {ld_len, ld.key};
    end
  end

  // Header clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      if (int'(clr_r) == SLOTS - 1) begin
        clearing_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  assign busy = clearing_r;

  // Header memory.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    hdr_q <= hdr_mem[hdr_addr];
  end

  assign hdr_len_q = hdr_q[LEN_W+KEY_W-1:KEY_W];
  assign hdr_key_q = hdr_q[KEY_W-1:0];

  // Entry unit memory.
  always_ff @(posedge clk) begin
    if (eu_we) begin
      eu_mem[eu_waddr] <= ld.unit;
    end
    eu_q <= eu_mem[eu_addr];
  end

  // Fuzzy partner memory with two read ports.
  always_ff @(posedge clk) begin
    if (fz_we) begin
      fz_mem[ld.unit.major[UIW-1:0]] <= ld.unit.minor;
    end
    fz_da <= fz_mem[fz_addr_a];
    fz_db <= fz_mem[fz_addr_b];
  end

  // Valid bits of the fuzzy table; an entry never written reads as no partner.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fz_vld_r <= '0;
      fz_va    <= 1'b0;
      fz_vb    <= 1'b0;
    end else begin
      if (fz_we) begin
        fz_vld_r[ld.unit.major[UIW-1:0]] <= 1'b1;
      end
      fz_va <= fz_vld_r[fz_addr_a];
      fz_vb <= fz_vld_r[fz_addr_b];
    end
  end

  assign fz_q_a = fz_va ? fz_da : NO_PARTNER;
  assign fz_q_b = fz_vb ? fz_db : NO_PARTNER;

  // Query unit registers.
  always_ff @(posedge clk) begin
    if (qry_we) begin
      qry_r[ld.position[PW-1:0]] <= ld.unit;
    end
  end

  assign qry_unit   = qry_r[qry_pos];
  assign qry_major0 = qry_r[0].major;

endmodule

`default_nettype wire

/* src/fpts_match.sv */
// Shared unit compare: one entry unit against one query unit, with fuzzy partners.
// Depends on fpts_pkg.
`default_nettype none

module fpts_match #(
  parameter int NUM_UNITS = fpts_pkg::DEF_NUM_UNITS
) (
  input  fpts_pkg::unit_t                    ent,
  input  fpts_pkg::unit_t                    qry,
  input  logic signed [fpts_pkg::UNIT_W-1:0] fz_major,
  input  logic signed [fpts_pkg::UNIT_W-1:0] fz_minor,
  input  logic                               fuzzy_en,
  output logic                               hit
);
  import fpts_pkg::*;

  logic major_ok, minor_ok;

  // The major must agree directly or through its partner; a wildcard minor always agrees.
  always_comb begin
    major_ok = (ent.major == qry.major) ||
               (fuzzy_en && unit_in_range(ent.major, NUM_UNITS) && (fz_major == qry.major));
    minor_ok = (qry.minor == NO_PARTNER) || (ent.minor == qry.minor) ||
               (fuzzy_en && unit_in_range(ent.minor, NUM_UNITS) && (fz_minor == qry.minor));
    hit      = major_ok && minor_ok;
  end

endmodule

`default_nettype wire

/* src/fpts_search.sv */
// Search sequencer: scans entries for both keys, builds sorted hit lists, merges them
// and drives the result register. Depends on fpts_pkg and on fpts_store read ports.
`default_nettype none

module fpts_search #(
  parameter int SLOTS     = fpts_pkg::DEF_SLOTS,
  parameter int MAX_LEN   = fpts_pkg::DEF_MAX_LEN,
  parameter int NUM_UNITS = fpts_pkg::DEF_NUM_UNITS,
  parameter int MAX_OUT   = fpts_pkg::DEF_MAX_OUT,
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW  = (SLOTS * MAX_LEN > 1) ? $clog2(SLOTS * MAX_LEN) : 1,
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int UIW = $clog2(NUM_UNITS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               start_prefer,
  input  logic [fpts_pkg::LEN_W-1:0]         start_count,
  input  fpts_pkg::cfg_t                     cfg,
  output logic                               idle,
  output logic [SW-1:0]                      hdr_addr,
  input  logic [fpts_pkg::LEN_W-1:0]         hdr_len_q,
  input  logic [fpts_pkg::KEY_W-1:0]         hdr_key_q,
  output logic [AW-1:0]                      eu_addr,
  input  fpts_pkg::unit_t                    eu_q,
  output logic [UIW-1:0]                     fz_addr_a,
  output logic [UIW-1:0]                     fz_addr_b,
  input  logic signed [fpts_pkg::UNIT_W-1:0] fz_q_a,
  output logic [PW-1:0]                      qry_pos,
  input  logic signed [fpts_pkg::UNIT_W-1:0] qry_major0,
  input  logic                               unit_hit,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fpts_pkg::res_t                     out_res
);
  import fpts_pkg::*;

  localparam int CW    = $clog2(SLOTS + 1);
  localparam int OW    = $clog2(MAX_OUT + 1);
  localparam int TAB_N = ((MAX_LEN < 15) ? MAX_LEN : 15) + 1;
  localparam int TW    = $clog2(TAB_N);

  srch_state_t              state_r, state_nxt;
  logic                     prefer_r, prefer_nxt;
  logic                     keysel_r, keysel_nxt;
  logic                     bal_r, bal_nxt;
  logic                     trunc_r, trunc_nxt;
  logic [LEN_W-1:0]         qlen_r, qlen_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LEN_W-1:0]         p_r, p_nxt;
  logic [LEN_W-1:0]         l_r, l_nxt;
  logic signed [UNIT_W-1:0] key_r, key_nxt;
  logic signed [UNIT_W-1:0] k2_r, k2_nxt;
  logic [SW-1:0]            s_r, s_nxt;
  logic [CW-1:0]            na_r, na_nxt, nb_r, nb_nxt;
  logic [CW-1:0]            sum_r, sum_nxt;
  logic [CW-1:0]            i_r, i_nxt, j_r, j_nxt;
  logic [OW-1:0]            emit_r, emit_nxt, limit_r, limit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     out_r, out_nxt;

  // Hit length per slot, the two sorted hit lists and the per-length count table.
  logic [LEN_W-1:0]         hit_mem [SLOTS];
  hit_t                     list_a [SLOTS];
  hit_t                     list_b [SLOTS];
  logic [CW-1:0]            tab_r [TAB_N];
  logic [LEN_W-1:0]         hit_q;
  hit_t                     qa, qb;

  logic                     hit_we;
  logic [LEN_W-1:0]         hit_wd;
  logic                     list_we;
  hit_t                     list_wd;
  logic                     tab_clr, tab_we;
  logic [TW-1:0]            tab_idx;
  logic [CW-1:0]            tab_wd, tab_rd;
  logic                     end_pass;
  logic [CW-1:0]            pass_cnt;
  logic                     key_ok, cand, out_free, last_slot;
  logic                     a_av, b_av, take_a;
  logic [CW:0]              total;
  hit_t                     pick;

  assign hdr_addr  = s_r;
  assign eu_addr   = AW'(AW'(s_r) * AW'(MAX_LEN)) + AW'(p_r);
  assign fz_addr_a = (state_r == S_UFZ) ? eu_q.major[UIW-1:0] : qry_major0[UIW-1:0];
  assign fz_addr_b = eu_q.minor[UIW-1:0];
  assign qry_pos   = p_r[PW-1:0];
  assign tab_rd    = tab_r[tab_idx];
  assign idle      = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Sequencer next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    prefer_nxt    = prefer_r;
    keysel_nxt    = keysel_r;
    bal_nxt       = bal_r;
    trunc_nxt     = trunc_r;
    qlen_nxt      = qlen_r;
    len_nxt       = len_r;
    p_nxt         = p_r;
    l_nxt         = l_r;
    key_nxt       = key_r;
    k2_nxt        = k2_r;
    s_nxt         = s_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    sum_nxt       = sum_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    emit_nxt      = emit_r;
    limit_nxt     = limit_r;
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    hit_we        = 1'b0;
    hit_wd        = '0;
    list_we       = 1'b0;
    list_wd       = '{slot: SLOT_W'(s_r), len: hit_q};
    tab_clr       = 1'b0;
    tab_we        = 1'b0;
    tab_idx       = TW'(len_r);
    tab_wd        = tab_rd + 1'b1;
    end_pass      = 1'b0;
    pass_cnt      = sum_r;
    last_slot     = (s_r == '0);
    key_ok        = !key_r[UNIT_W-1] && ({1'b0, key_r[KEY_W-1:0]} < cfg.key_count) &&
                    (qlen_r != '0);
    cand          = (hdr_key_q == key_r[KEY_W-1:0]) && (hdr_len_q != '0) &&
                    (hdr_len_q <= qlen_r);
    total         = {1'b0, na_r} + {1'b0, nb_r};
    a_av          = i_r < na_r;
    b_av          = j_r < nb_r;
    take_a        = a_av;
    if (!prefer_r && a_av && b_av) begin
      take_a = (qa.len > qb.len) || ((qa.len == qb.len) && !bal_r);
    end
    pick          = take_a ? qa : qb;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          prefer_nxt = start_prefer;
          qlen_nxt   = (int'(start_count) > MAX_LEN) ? LEN_W'(MAX_LEN) : start_count;
          state_nxt  = S_KEY;
        end
      end
      // Partner key lookup of the first query major.
      S_KEY: begin
        state_nxt = S_KEYW;
      end
      S_KEYW: begin
        key_nxt    = qry_major0;
        k2_nxt     = (cfg.fuzzy_en && unit_in_range(qry_major0, NUM_UNITS)) ? fz_q_a
                                                                           : NO_PARTNER;
        keysel_nxt = 1'b0;
        state_nxt  = S_PINIT;
      end
      S_PINIT: begin
        tab_clr = 1'b1;
        s_nxt   = SW'(SLOTS - 1);
        l_nxt   = qlen_r;
        sum_nxt = '0;
        if (key_ok) begin
          state_nxt = S_PHDR;
        end else begin
          end_pass = 1'b1;
          pass_cnt = '0;
        end
      end
      S_PHDR: begin
        state_nxt = S_PCHK;
      end
      // Header check: only entries of this key and a usable length are compared.
      S_PCHK: begin
        len_nxt = hdr_len_q;
        p_nxt   = '0;
        if (cand) begin
          state_nxt = S_URD;
        end else begin
          hit_we = 1'b1;
          if (last_slot) begin
            state_nxt = S_POFF;
          end else begin
            s_nxt     = s_r - 1'b1;
            state_nxt = S_PHDR;
          end
        end
      end
      S_URD: begin
        state_nxt = S_UFZ;
      end
      S_UFZ: begin
        state_nxt = S_UCMP;
      end
      // Unit compare, one unit position per round.
      S_UCMP: begin
        if (unit_hit && (p_r != len_r - 1'b1)) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_URD;
        end else begin
          hit_we = 1'b1;
          if (unit_hit) begin
            hit_wd = len_r;
            tab_we = 1'b1;
          end
          if (last_slot) begin
            state_nxt = S_POFF;
          end else begin
            s_nxt     = s_r - 1'b1;
            state_nxt = S_PHDR;
          end
        end
      end
      // Turn per-length counts into list start offsets, longest length first.
      S_POFF: begin
        tab_idx = TW'(l_r);
        tab_we  = 1'b1;
        tab_wd  = sum_r;
        sum_nxt = sum_r + tab_rd;
        if (l_r == LEN_W'(1)) begin
          s_nxt     = SW'(SLOTS - 1);
          state_nxt = S_PLRD;
        end else begin
          l_nxt = l_r - 1'b1;
        end
      end
      S_PLRD: begin
        state_nxt = S_PLWR;
      end
      // Place each hit at the next free offset of its length.
      S_PLWR: begin
        tab_idx = TW'(hit_q);
        if (hit_q != '0) begin
          list_we = 1'b1;
          tab_we  = 1'b1;
        end
        if (last_slot) begin
          end_pass = 1'b1;
        end else begin
          s_nxt     = s_r - 1'b1;
          state_nxt = S_PLRD;
        end
      end
      S_MINIT: begin
        i_nxt     = '0;
        j_nxt     = '0;
        bal_nxt   = 1'b0;
        emit_nxt  = '0;
        trunc_nxt = !prefer_r && (total > (CW+1)'(MAX_OUT));
        if (prefer_r) begin
          limit_nxt = OW'(total != '0);
        end else begin
          limit_nxt = (total > (CW+1)'(MAX_OUT)) ? OW'(MAX_OUT) : OW'(total);
        end
        state_nxt = (total == '0) ? S_MNONE : S_MRD;
      end
      S_MRD: begin
        state_nxt = S_MPICK;
      end
      // Merge step: the longer head goes first, equal lengths alternate; a prefer search takes list A first.
      S_MPICK: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.found      = 1'b1;
          out_nxt.phrase_ref = cfg.data_base + (REF_W'(pick.slot) << 3);
          out_nxt.hit_slot   = pick.slot;
          out_nxt.hit_length = pick.len;
          out_nxt.truncated  = trunc_r;
          out_nxt.last       = (emit_r + 1'b1 == limit_r);
          if (take_a) begin
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          if (a_av && b_av) begin
            bal_nxt = (qa.len != qb.len) ? 1'b0 : take_a;
          end
          emit_nxt  = emit_r + 1'b1;
          state_nxt = (emit_r + 1'b1 == limit_r) ? S_IDLE : S_MRD;
        end
      end
      S_MNONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b0, phrase_ref: '0, hit_slot: '0, hit_length: '0,
                            truncated: 1'b0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of one key pass: the second key follows the first, then the merge.
    if (end_pass) begin
      if (!keysel_r) begin
        na_nxt     = pass_cnt;
        keysel_nxt = 1'b1;
        key_nxt    = k2_r;
        state_nxt  = S_PINIT;
      end else begin
        nb_nxt    = pass_cnt;
        state_nxt = S_MINIT;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the current search.
  always_ff @(posedge clk) begin
    prefer_r <= prefer_nxt;
    keysel_r <= keysel_nxt;
    bal_r    <= bal_nxt;
    trunc_r  <= trunc_nxt;
    qlen_r   <= qlen_nxt;
    len_r    <= len_nxt;
    p_r      <= p_nxt;
    l_r      <= l_nxt;
    key_r    <= key_nxt;
    k2_r     <= k2_nxt;
    s_r      <= s_nxt;
    na_r     <= na_nxt;
    nb_r     <= nb_nxt;
    sum_r    <= sum_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    emit_r   <= emit_nxt;
    limit_r  <= limit_nxt;
    out_r    <= out_nxt;
  end

  // Count table.
  always_ff @(posedge clk) begin
    if (tab_clr) begin
      for (int k = 0; k < TAB_N; k++) begin
        tab_r[k] <= '0;
      end
    end else if (tab_we) begin
      tab_r[tab_idx] <= tab_wd;
    end
  end

  // Hit length memory.
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[s_r] <= hit_wd;
    end
    hit_q <= hit_mem[s_r];
  end

  // Sorted hit list memories, one per key.
  always_ff @(posedge clk) begin
    if (list_we && !keysel_r) begin
      list_a[tab_rd[SW-1:0]] <= list_wd;
    end
    if (list_we && keysel_r) begin
      list_b[tab_rd[SW-1:0]] <= list_wd;
    end
    qa <= list_a[i_r[SW-1:0]];
    qb <= list_b[j_r[SW-1:0]];
  end

  // A search starts only from idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("search started while busy");

  // A merge step always has a list head left to take.
  a_pick_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MPICK && out_free) |-> (i_r < na_r) || (j_r < nb_r))
    else $error("merge step with both lists exhausted");

  // The merge never sends more results than its limit.
  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MPICK |-> emit_r < limit_r)
    else $error("result count beyond limit");

  // A result without a hit closes its search and is never truncated.
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.last && !out_r.truncated))
    else $error("no-hit result malformed");

endmodule

`default_nettype wire

/* src/fuzzy_phrase_table_search_unit.sv */
// Top level of the fuzzy phrase table search unit: configuration registers, request
// decode and the store, compare and search sequencer. Depends on fpts_pkg and fpts_if.
`default_nettype none

// Load requests (entry unit, entry header, fuzzy entry, query unit) can be taken back to
// back and cause no result. A search handles the two keys in turn: for each key below
// the key count, with a nonzero query length, it walks every slot for the header check
// and unit compares, turns the per-length hit counts into list offsets longest first and
// walks every slot again to place the hits. The merge then sends the results one at a
// time, waiting while the result register holds one not yet taken. The search speed is
// set by the single-ported header, unit and hit memories and the shared unit compare.
// The request side is not ready while a search runs. After reset a clearing pass sweeps
// over the entry headers, during which no request is taken; configuration writes are
// taken at any time and must only be made while the block is idle.
module fuzzy_phrase_table_search_unit #(
  parameter int SLOTS     = fpts_pkg::DEF_SLOTS,
  parameter int MAX_LEN   = fpts_pkg::DEF_MAX_LEN,
  parameter int NUM_UNITS = fpts_pkg::DEF_NUM_UNITS,
  parameter int MAX_OUT   = fpts_pkg::DEF_MAX_OUT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fpts_in_if.sink                       in_req,
  fpts_out_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [fpts_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fpts_pkg::REF_W-1:0]    cfg_wdata
);
  import fpts_pkg::*;

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW  = (SLOTS * MAX_LEN > 1) ? $clog2(SLOTS * MAX_LEN) : 1;
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int UIW = $clog2(NUM_UNITS);

  cfg_t                     cfg_r;
  load_t                    ld;
  logic                     accept, store_busy, srch_idle, start;
  logic [SW-1:0]            hdr_addr;
  logic [LEN_W-1:0]         hdr_len_q;
  logic [KEY_W-1:0]         hdr_key_q;
  logic [AW-1:0]            eu_addr;
  unit_t                    eu_q, qry_unit;
  logic [UIW-1:0]           fz_addr_a, fz_addr_b;
  logic signed [UNIT_W-1:0] fz_q_a, fz_q_b, qry_major0;
  logic [PW-1:0]            qry_pos;
  logic                     unit_hit, res_valid;
  res_t                     res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FUZZY_EN:  cfg_r.fuzzy_en  <= cfg_wdata[0];
        REG_KEY_COUNT: cfg_r.key_count <= cfg_wdata[KCNT_W-1:0];
        REG_DATA_BASE: cfg_r.data_base <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Request decode.
  assign in_req.ready = !store_busy && srch_idle;
  assign accept       = in_req.valid && in_req.ready;
  assign start        = accept && ((in_req.cmd == CMD_ALL) || (in_req.cmd == CMD_PREFER));
  assign ld = '{cmd: in_req.cmd, slot: in_req.slot, position: in_req.position,
                unit: '{major: in_req.unit_major, minor: in_req.unit_minor},
                key: in_req.entry_key, count: in_req.unit_count};

  fpts_store #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN), .NUM_UNITS(NUM_UNITS)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (accept),
    .ld         (ld),
    .busy       (store_busy),
    .hdr_addr   (hdr_addr),
    .hdr_len_q  (hdr_len_q),
    .hdr_key_q  (hdr_key_q),
    .eu_addr    (eu_addr),
    .eu_q       (eu_q),
    .fz_addr_a  (fz_addr_a),
    .fz_addr_b  (fz_addr_b),
    .fz_q_a     (fz_q_a),
    .fz_q_b     (fz_q_b),
    .qry_pos    (qry_pos),
    .qry_unit   (qry_unit),
    .qry_major0 (qry_major0)
  );

  fpts_match #(.NUM_UNITS(NUM_UNITS)) u_match (
    .ent      (eu_q),
    .qry      (qry_unit),
    .fz_major (fz_q_a),
    .fz_minor (fz_q_b),
    .fuzzy_en (cfg_r.fuzzy_en),
    .hit      (unit_hit)
  );

  fpts_search #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN), .NUM_UNITS(NUM_UNITS),
                .MAX_OUT(MAX_OUT)) u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .start_prefer (in_req.cmd == CMD_PREFER),
    .start_count  (in_req.unit_count),
    .cfg          (cfg_r),
    .idle         (srch_idle),
    .hdr_addr     (hdr_addr),
    .hdr_len_q    (hdr_len_q),
    .hdr_key_q    (hdr_key_q),
    .eu_addr      (eu_addr),
    .eu_q         (eu_q),
    .fz_addr_a    (fz_addr_a),
    .fz_addr_b    (fz_addr_b),
    .fz_q_a       (fz_q_a),
    .qry_pos      (qry_pos),
    .qry_major0   (qry_major0),
    .unit_hit     (unit_hit),
    .out_valid    (res_valid),
    .out_ready    (out_res.ready),
    .out_res      (res)
  );

  // Result channel.
  assign out_res.valid      = res_valid;
  assign out_res.found      = res.found;
  assign out_res.phrase_ref = res.phrase_ref;
  assign out_res.hit_slot   = res.hit_slot;
  assign out_res.hit_length = res.hit_length;
  assign out_res.truncated  = res.truncated;
  assign out_res.last       = res.last;

endmodule

`default_nettype wire

/* test/tb_fuzzy_phrase_table_search_unit.sv */
// Self-checking testbench for the fuzzy phrase table search unit: a directed pass, a hit
// overflow pass and random phases, all checked against an in-bench model of the table.
// Depends on fpts_pkg, fpts_in_if, fpts_out_if and fuzzy_phrase_table_search_unit.
`default_nettype none

module tb_fuzzy_phrase_table_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fpts_pkg::*;

  localparam int NSLOT = DEF_SLOTS;
  localparam int NLEN  = DEF_MAX_LEN;
  localparam int NUNIT = DEF_NUM_UNITS;
  localparam int NOUT  = DEF_MAX_OUT;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [REF_W-1:0] cfg_wdata;

  fpts_in_if  req_if ();
  fpts_out_if res_if ();

  fuzzy_phrase_table_search_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the phrase table, fuzzy partners, query and registers.
  unit_t                    phrase_units [NSLOT][NLEN];
  logic [LEN_W-1:0]         phrase_len [NSLOT];
  logic [KEY_W-1:0]         phrase_key [NSLOT];
  logic signed [UNIT_W-1:0] partner_map [NUNIT];
  unit_t                    query_units [NLEN];
  cfg_t                     regs;
  res_t                     pending_hits [$];
  int                       error_count;
  int                       burst_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #200_000_000;
    $display("fuzzy_phrase_table_search_unit verification failed");
    $finish;
  end

  // Partner of a unit index, or a value that never equals any 8-bit index.
  function automatic int partner_of(int v);
    if (!regs.fuzzy_en || v < 0 || v >= NUNIT) return -1000;
    return int'(partner_map[v]);
  endfunction

  function automatic bit entry_hits_query(int s, int len);
    int em, en, qm, qn;
    for (int p = 0; p < len; p++) begin
      em = int'($signed(phrase_units[s][p].major));
      en = int'($signed(phrase_units[s][p].minor));
      qm = int'($signed(query_units[p].major));
      qn = int'($signed(query_units[p].minor));
      if (em != qm && partner_of(em) != qm) return 0;
      if (qn != -1 && en != qn && partner_of(en) != qn) return 0;
    end
    return 1;
  endfunction

  // Hits under one key, longest first and then highest slot first.
  function automatic void gather_hits(int key, int qlen, ref int hits[$]);
    hits.delete();
    if (qlen == 0 || key < 0 || key >= int'(regs.key_count)) return;
    for (int len = qlen; len >= 1; len--)
      for (int s = NSLOT - 1; s >= 0; s--)
        if (int'(phrase_len[s]) == len && int'(phrase_key[s]) == key &&
            entry_hits_query(s, len))
          hits.push_back(s);
  endfunction

  function automatic res_t hit_result(bit found, int s, bit trunc, bit fin);
    res_t r;
    r.found      = found;
    r.phrase_ref = found ? regs.data_base + REF_W'(8 * s) : '0;
    r.hit_slot   = found ? SLOT_W'(s) : '0;
    r.hit_length = found ? phrase_len[s] : '0;
    r.truncated  = trunc;
    r.last       = fin;
    return r;
  endfunction

  // Applies one accepted request to the model and queues the results it causes.
  function automatic void predict_request(load_t r);
    int qlen, q0, k2, i, j, bal, la, lb, pick;
    int list_a[$];
    int list_b[$];
    int merged[$];
    qlen = (r.count > NLEN) ? NLEN : int'(r.count);
    case (r.cmd)
      CMD_UNIT: phrase_units[r.slot][r.position] = r.unit;
      CMD_HDR: begin
        phrase_len[r.slot] = LEN_W'(qlen);
        phrase_key[r.slot] = r.key;
      end
      CMD_FUZZY:
        if ($signed(r.unit.major) >= 0) partner_map[r.unit.major] = r.unit.minor;
      CMD_QUERY: query_units[r.position] = r.unit;
      CMD_ALL, CMD_PREFER: begin
        q0 = int'($signed(query_units[0].major));
        k2 = (regs.fuzzy_en && q0 >= 0) ? int'(partner_map[q0]) : -1;
        gather_hits(q0, qlen, list_a);
        gather_hits(k2, qlen, list_b);
        if (r.cmd == CMD_PREFER) begin
          if (list_a.size() > 0) pending_hits.push_back(hit_result(1, list_a[0], 0, 1));
          else if (list_b.size() > 0)
            pending_hits.push_back(hit_result(1, list_b[0], 0, 1));
          else pending_hits.push_back(hit_result(0, 0, 0, 1));
        end else begin
          i = 0;
          j = 0;
          bal = 0;
          while (i < list_a.size() || j < list_b.size()) begin
            if (i < list_a.size() && j < list_b.size()) begin
              la = phrase_len[list_a[i]];
              lb = phrase_len[list_b[j]];
              if (la > lb || (la == lb && bal <= 0)) begin
                pick = list_a[i++];
                bal++;
              end else begin
                pick = list_b[j++];
                bal--;
              end
              if (la != lb) bal = 0;
            end else if (i < list_a.size()) begin
              pick = list_a[i++];
            end else begin
              pick = list_b[j++];
            end
            merged.push_back(pick);
          end
          if (merged.size() == 0) begin
            pending_hits.push_back(hit_result(0, 0, 0, 1));
          end else begin
            for (int k = 0; k < merged.size() && k < NOUT; k++)
              pending_hits.push_back(hit_result(1, merged[k], merged.size() > NOUT,
                                                k + 1 == merged.size() || k + 1 == NOUT));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Sends one request in bursts with random gaps; returns at the falling edge after it.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input int slot, input int pos,
                          input int major, input int minor, input int key, input int count);
    load_t r;
    int gap;
    r.cmd        = cmd;
    r.slot       = SLOT_W'(slot);
    r.position   = POS_W'(pos);
    r.unit.major = UNIT_W'(major);
    r.unit.minor = UNIT_W'(minor);
    r.key        = KEY_W'(key);
    r.count      = LEN_W'(count);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.cmd        <= r.cmd;
    req_if.slot       <= r.slot;
    req_if.position   <= r.position;
    req_if.unit_major <= r.unit.major;
    req_if.unit_minor <= r.unit.minor;
    req_if.entry_key  <= r.key;
    req_if.unit_count <= r.count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_request(r);
    @(negedge clk);
  endtask

  // Loads an entry: every unit it covers first, then its header.
  task automatic load_entry(input int slot, input int key, input int count, input int major0);
    int mj;
    for (int p = 0; p < count && p < NLEN; p++) begin
      if ($urandom_range(0, 9) == 0) mj = $urandom_range(0, 255);
      else mj = (p == 0) ? major0 : $urandom_range(0, 5);
      send_req(CMD_UNIT, slot, p, mj,
               ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 5), 0, 0);
    end
    send_req(CMD_HDR, slot, $urandom_range(0, 7), $urandom_range(0, 255),
             $urandom_range(0, 255), key, count);
  endtask

  // Holds the request side until every expected result has arrived, then settles.
  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_config(input logic fen, input logic [KCNT_W-1:0] kc,
                            input logic [REF_W-1:0] base);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FUZZY_EN;
    cfg_wdata <= REF_W'(fen);
    @(negedge clk);
    cfg_index <= REG_KEY_COUNT;
    cfg_wdata <= REF_W'(kc);
    @(negedge clk);
    cfg_index <= REG_DATA_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_we <= 1'b0;
    regs.fuzzy_en  = fen;
    regs.key_count = kc;
    regs.data_base = base;
  endtask

  // Extremes of the fields, both search kinds, long and empty queries, a fuzzy entry for unit -5.
  task automatic test_directed();
    set_config(1'b1, 8'd128, 32'hFFFF_FFF8);
    send_req(CMD_QUERY, 0, 0, 2, -1, 0, 0);
    for (int p = 1; p < NLEN; p++) send_req(CMD_QUERY, 0, p, -1, -1, 0, 0);
    send_req(CMD_UNIT, 1023, 0, 2, 5, 0, 0);
    send_req(CMD_HDR, 1023, 7, -128, 127, 2, 1);
    send_req(CMD_UNIT, 0, 0, 2, 7, 0, 0);
    // Entry major 50 has no partner, so it matches a query major of -1.
    send_req(CMD_UNIT, 0, 1, 50, -1, 0, 0);
    send_req(CMD_HDR, 0, 0, 0, 0, 2, 2);
    send_req(CMD_FUZZY, 0, 0, 2, 3, 0, 0);
    send_req(CMD_FUZZY, 0, 0, 3, 2, 0, 0);
    send_req(CMD_UNIT, 5, 0, 3, 127, 0, 0);
    send_req(CMD_HDR, 5, 0, 0, 0, 3, 1);
    send_req(CMD_ALL, 0, 0, 0, 0, 0, 15);
    send_req(CMD_PREFER, 0, 0, 0, 0, 0, 0);
    send_req(CMD_ALL, 0, 0, 0, 0, 0, 2);
    send_req(3'd6, 1023, 7, -1, -1, 127, 15);
    send_req(3'd7, 0, 0, 0, 0, 0, 0);
    send_req(CMD_FUZZY, 0, 0, -5, 9, 0, 0);
    send_req(CMD_PREFER, 0, 0, 0, 0, 0, 8);
  endtask

  // A key whose partner is itself doubles every hit and overflows the result limit.
  task automatic test_overflow();
    set_config(1'b1, 8'd128, $urandom);
    send_req(CMD_FUZZY, 0, 0, 9, 9, 0, 0);
    for (int s = 600; s < 633; s++) begin
      send_req(CMD_UNIT, s, 0, 9, $urandom_range(0, 3), 0, 0);
      send_req(CMD_HDR, s, 0, 0, 0, 9, 1);
    end
    send_req(CMD_QUERY, 0, 0, 9, -1, 0, 0);
    send_req(CMD_ALL, 0, 0, 0, 0, 0, 1);
    send_req(CMD_PREFER, 0, 0, 0, 0, 0, 3);
  endtask

  // Random phases over several register settings, mostly well-formed loads and queries.
  task automatic test_random();
    int pick, key, cnt;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1'b0, 8'd0, 32'h0);
        1: set_config(1'b1, 8'hFF, 32'hFFFF_FFFF);
        2: set_config(1'b1, 8'd4, $urandom);
        3: set_config(1'b0, 8'd128, $urandom);
        4: set_config(1'b1, 8'd3, $urandom);
        default: set_config(1'b1, 8'd128, $urandom);
      endcase
      for (int n = 0; n < 12; n++) begin
        pick = $urandom_range(0, 99);
        key = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
        if (pick < 40) begin
          cnt = $urandom_range(0, 9);
          cnt = (cnt == 9) ? $urandom_range(9, 15) : cnt;
          load_entry($urandom_range(0, 1023), key, cnt, key);
        end else if (pick < 52) begin
          if ($urandom_range(0, 5) == 0)
            send_req(CMD_FUZZY, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0);
          else
            send_req(CMD_FUZZY, $urandom_range(0, 1023), 0, $urandom_range(0, 7),
                     ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 7), 0, 0);
        end else if (pick < 66) begin
          send_req(CMD_QUERY, 0, $urandom_range(0, 7), $urandom_range(0, 5),
                   ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 5), 0, 0);
        end else if (pick < 86) begin
          if ($urandom_range(0, 1) == 0)
            send_req(CMD_QUERY, 0, 0, key, ($urandom_range(0, 1) == 0) ? -1 : key, 0, 0);
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          send_req(($urandom_range(0, 1) == 0) ? CMD_ALL : CMD_PREFER,
                   $urandom_range(0, 1023), $urandom_range(0, 7), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 127), cnt);
        end else if (pick < 93) begin
          send_req(CMD_UNIT, $urandom_range(0, 1023), $urandom_range(0, 7),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127),
                   $urandom_range(0, 15));
        end else begin
          send_req(CMD_W'(CMD_PREFER + $urandom_range(1, 2)), $urandom_range(0, 1023),
                   $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 127), $urandom_range(0, 15));
        end
      end
    end
  endtask

  // Result receiver: stalls on a rotating pattern, sometimes not at all.
  logic [7:0] stall_pattern;
  int         pattern_age;
  always @(negedge clk) begin
    if (pattern_age == 0) begin
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      pattern_age   <= $urandom_range(50, 300);
    end else begin
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
      pattern_age   <= pattern_age - 1;
    end
    res_if.ready <= stall_pattern[0] | (stall_pattern == 8'h00);
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d", $realtime,
                 res_if.hit_slot);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        check_field("found", want.found, res_if.found);
        check_field("phrase_ref", want.phrase_ref, res_if.phrase_ref);
        check_field("hit_slot", want.hit_slot, res_if.hit_slot);
        check_field("hit_length", want.hit_length, res_if.hit_length);
        check_field("truncated", want.truncated, res_if.truncated);
        check_field("last", want.last, res_if.last);
      end
    end
  end

  initial begin
    error_count   = 0;
    burst_left    = 0;
    pattern_age   = 0;
    stall_pattern = 8'hFF;
    regs          = '0;
    for (int s = 0; s < NSLOT; s++) begin
      phrase_len[s] = '0;
      phrase_key[s] = '0;
    end
    for (int u = 0; u < NUNIT; u++) partner_map[u] = NO_PARTNER;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.cmd        = '0;
    req_if.slot       = '0;
    req_if.position   = '0;
    req_if.unit_major = '0;
    req_if.unit_minor = '0;
    req_if.entry_key  = '0;
    req_if.unit_count = '0;
    res_if.ready      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_overflow();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_hits.size() == 0) begin
      $display("fuzzy_phrase_table_search_unit verification clean");
    end else begin
      $display("fuzzy_phrase_table_search_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
